### src/fsnf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsnf_pkg: shared types and constants for the FAT short name formatter
// Character classes passed from the front end to the builder, status codes,
// and the character tests used by the front end.
// ----------------------------------------------------------------------------
package fsnf_pkg;

    localparam int NAME_LEN  = 11;
    localparam int BASE_LEN  = 8;
    localparam int EXT_LEN   = NAME_LEN - BASE_LEN;
    localparam int BASE_LAST = 7;
    localparam int FULL_LAST = 10;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] PRINT_LOW  = 8'h21;
    localparam logic [7:0] PRINT_HIGH = 8'h7E;
    localparam logic [7:0] LOWER_A    = 8'h61;
    localparam logic [7:0] LOWER_Z    = 8'h7A;
    localparam logic [7:0] CASE_DIFF  = 8'h20;

    localparam logic [3:0] POS_EXT       = 4'd8;
    localparam logic [3:0] POS_BASE_LAST = 4'd7;
    localparam logic [3:0] POS_FULL_LAST = 4'd10;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_DOT   = 3'd1,
        ST_BAD   = 3'd2,
        ST_LONG  = 3'd3,
        ST_EMPTY = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        KIND_TERM,
        KIND_DOT,
        KIND_BAD,
        KIND_NONPRINT,
        KIND_CHAR
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] ch;
    } entry_t;

    function automatic logic is_bad_char(input logic [7:0] c);
        logic bad;
        case (c) inside
            8'h7C, 8'h3C, 8'h3E, 8'h5E, 8'h2B, 8'h3D, 8'h3F, 8'h2F,
            8'h5B, 8'h5D, 8'h3B, 8'h2C, 8'h2A, 8'h22, 8'h5C: bad = 1'b1;
            default: bad = 1'b0;
        endcase
        return bad;
    endfunction

endpackage
`default_nettype wire

### src/fsnf_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsnf_front: character classifier
// Sorts each path byte into terminator, dot, forbidden, nonprintable or
// ordinary character, and folds lower case to upper case.
// ----------------------------------------------------------------------------
module fsnf_front (
    input  wire logic [7:0]      ch,
    output fsnf_pkg::entry_t     entry
);

    always_comb begin
        entry.ch   = ch;
        entry.kind = fsnf_pkg::KIND_CHAR;
        if (ch == fsnf_pkg::CH_NUL || ch == fsnf_pkg::CH_SLASH) begin
            entry.kind = fsnf_pkg::KIND_TERM;
        end else if (ch == fsnf_pkg::CH_DOT) begin
            entry.kind = fsnf_pkg::KIND_DOT;
        end else if (fsnf_pkg::is_bad_char(ch)) begin
            entry.kind = fsnf_pkg::KIND_BAD;
        end else if (ch < fsnf_pkg::PRINT_LOW || ch > fsnf_pkg::PRINT_HIGH) begin
            entry.kind = fsnf_pkg::KIND_NONPRINT;
        end else if (ch >= fsnf_pkg::LOWER_A && ch <= fsnf_pkg::LOWER_Z) begin
            entry.ch = ch - fsnf_pkg::CASE_DIFF;
        end
    end

endmodule
`default_nettype wire

### src/fsnf_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsnf_queue: small FIFO between classifier and builder
// Register-based queue; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module fsnf_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       push,
    input  wire fsnf_pkg::entry_t           push_entry,
    output logic                            full,
    input  wire logic                       pop,
    output logic                            not_empty,
    output fsnf_pkg::entry_t                head,
    output logic [$clog2(DEPTH+1)-1:0]      count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    fsnf_pkg::entry_t mem_reg [DEPTH];
    logic [PW-1:0] wr_reg, wr_next;
    logic [PW-1:0] rd_reg, rd_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_push, do_pop;

    assign full      = (cnt_reg == CNT_FULL);
    assign not_empty = (cnt_reg != '0);
    assign head      = mem_reg[rd_reg];
    assign count     = cnt_reg;
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push) begin
            wr_next = (wr_reg == PTR_LAST) ? '0 : wr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_next = (rd_reg == PTR_LAST) ? '0 : rd_reg + PW'(1);
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_reg] <= push_entry;
        end
    end

endmodule
`default_nettype wire

### src/fsnf_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsnf_back: name builder
// Applies classified characters to the name buffer, tracks the first error,
// and loads a result into the output register on each terminator.
// ----------------------------------------------------------------------------
module fsnf_back (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    input  wire fsnf_pkg::entry_t    in_entry,
    output logic                     in_pop,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output fsnf_pkg::status_t        out_status,
    output logic [63:0]              out_base,
    output logic [23:0]              out_ext
);

    logic [7:0]        name_reg [fsnf_pkg::NAME_LEN];
    logic [7:0]        name_next [fsnf_pkg::NAME_LEN];
    logic [3:0]        pos_reg, pos_next;
    logic              dot_reg, dot_next;
    fsnf_pkg::status_t err_reg, err_next;
    logic              valid_reg, valid_next;
    fsnf_pkg::status_t status_reg, status_next;
    logic [63:0]       base_reg, base_next;
    logic [23:0]       ext_reg, ext_next;
    logic [3:0]        limit;
    logic              out_free;

    assign out_free   = !valid_reg || out_ready;
    assign in_pop     = in_valid && (in_entry.kind != fsnf_pkg::KIND_TERM || out_free);
    assign limit      = dot_reg ? fsnf_pkg::POS_FULL_LAST : fsnf_pkg::POS_BASE_LAST;
    assign out_valid  = valid_reg;
    assign out_status = status_reg;
    assign out_base   = base_reg;
    assign out_ext    = ext_reg;

    always_comb begin
        name_next   = name_reg;
        pos_next    = pos_reg;
        dot_next    = dot_reg;
        err_next    = err_reg;
        status_next = status_reg;
        base_next   = base_reg;
        ext_next    = ext_reg;
        valid_next  = valid_reg && !out_ready;
        if (in_pop) begin
            unique case (in_entry.kind)
                fsnf_pkg::KIND_TERM: begin
                    valid_next = 1'b1;
                    for (int k = 0; k < fsnf_pkg::BASE_LEN; k++) begin
                        base_next[63-8*k -: 8] = name_reg[k];
                    end
                    for (int k = 0; k < fsnf_pkg::EXT_LEN; k++) begin
                        ext_next[23-8*k -: 8] = name_reg[fsnf_pkg::BASE_LEN+k];
                    end
                    if (err_reg != fsnf_pkg::ST_OK) begin
                        status_next = err_reg;
                    end else if (name_reg[0] == fsnf_pkg::CH_SPACE) begin
                        status_next = fsnf_pkg::ST_EMPTY;
                    end else begin
                        status_next = fsnf_pkg::ST_OK;
                    end
                    // start the next component from a blank buffer
                    for (int k = 0; k < fsnf_pkg::NAME_LEN; k++) begin
                        name_next[k] = fsnf_pkg::CH_SPACE;
                    end
                    pos_next = '0;
                    dot_next = 1'b0;
                    err_next = fsnf_pkg::ST_OK;
                end
                fsnf_pkg::KIND_DOT: begin
                    if (err_reg == fsnf_pkg::ST_OK) begin
                        if (dot_reg) begin
                            err_next = fsnf_pkg::ST_DOT;
                        end else begin
                            dot_next = 1'b1;
                            pos_next = fsnf_pkg::POS_EXT;
                        end
                    end
                end
                fsnf_pkg::KIND_BAD: begin
                    if (err_reg == fsnf_pkg::ST_OK) begin
                        err_next = fsnf_pkg::ST_BAD;
                    end
                end
                fsnf_pkg::KIND_NONPRINT: begin
                    if (err_reg == fsnf_pkg::ST_OK) begin
                        err_next = fsnf_pkg::ST_LONG;
                    end
                end
                fsnf_pkg::KIND_CHAR: begin
                    if (err_reg == fsnf_pkg::ST_OK) begin
                        if (pos_reg > limit) begin
                            err_next = fsnf_pkg::ST_LONG;
                        end else begin
                            name_next[pos_reg] = in_entry.ch;
                            pos_next = pos_reg + 4'd1;
                        end
                    end
                end
                default: begin
                    err_next = err_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < fsnf_pkg::NAME_LEN; k++) begin
                name_reg[k] <= fsnf_pkg::CH_SPACE;
            end
            pos_reg   <= '0;
            dot_reg   <= 1'b0;
            err_reg   <= fsnf_pkg::ST_OK;
            valid_reg <= 1'b0;
        end else begin
            name_reg  <= name_next;
            pos_reg   <= pos_next;
            dot_reg   <= dot_next;
            err_reg   <= err_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        base_reg   <= base_next;
        ext_reg    <= ext_next;
    end

endmodule
`default_nettype wire

### src/fat_short_name_formatter_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// A terminator beat passes the queue register and then the builder's output register before
// its result shows on m_tvalid; bytes queued ahead of it are retired first.
// Throughput: one path byte per cycle while s_tready is high; the builder retires one
// queued byte per cycle unless a terminator waits on m_tready. s_tready drops only when
// the QUEUE_DEPTH-entry queue is full, as bytes pile up behind such a terminator.
// Reset: aresetn (synchronous, active low) empties the queue, drops m_tvalid and
// fills the name buffer with spaces.
// ----------------------------------------------------------------------------
// fat_short_name_formatter_unit: FAT 8.3 short name formatter
// Classifier front end, character queue and name builder back end.
// ----------------------------------------------------------------------------
module fat_short_name_formatter_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] ch
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [95:0]      m_tdata    // [2:0] status, [66:3] base_name, [90:67] extension
);

    fsnf_pkg::entry_t               cls_entry;
    fsnf_pkg::entry_t               q_head;
    logic                           q_full;
    logic                           q_valid;
    logic                           q_pop;
    logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;
    fsnf_pkg::status_t              res_status;
    logic [63:0]                    res_base;
    logic [23:0]                    res_ext;

    fsnf_front u_front (
        .ch    (s_tdata),
        .entry (cls_entry)
    );

    fsnf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (s_tvalid),
        .push_entry (cls_entry),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_valid),
        .head       (q_head),
        .count      (q_count)
    );

    fsnf_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (q_valid),
        .in_entry   (q_head),
        .in_pop     (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (res_status),
        .out_base   (res_base),
        .out_ext    (res_ext)
    );

    assign s_tready = !q_full;
    assign m_tdata  = {5'd0, res_ext, res_base, res_status};

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2:0] <= 3'(fsnf_pkg::ST_EMPTY)))
        else $error("result status out of range");

    a_ok_has_base: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[2:0] == 3'(fsnf_pkg::ST_OK)) |->
        (m_tdata[66:59] != fsnf_pkg::CH_SPACE))
        else $error("ok status with empty base name");

    a_empty_blank: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[2:0] == 3'(fsnf_pkg::ST_EMPTY)) |->
        (m_tdata[66:59] == fsnf_pkg::CH_SPACE))
        else $error("empty status with a stored base character");

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
        else $error("queue count above depth");

endmodule
`default_nettype wire
